[rtl/core/two_axis_rate_accel_limiter_defines.svh]
// Assertion helpers shared by the limiter RTL.
`ifndef TWO_AXIS_RATE_ACCEL_LIMITER_DEFINES_SVH
`define TWO_AXIS_RATE_ACCEL_LIMITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TARL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("limiter check failed");

// The consequent must hold in the cycle after the antecedent.
`define TARL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("limiter check failed");

`endif

[rtl/core/tarl_pkg.sv]
`timescale 1ns / 1ps
package tarl_pkg;

   localparam int ANGLE_W   = 26;
   localparam int LIMIT_W   = 31;
   localparam int ELAPSED_W = 20;
   localparam int TAG_W     = 32;
   localparam int STATE_W   = 32;
   localparam int DT_W      = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 31;

   // Divider geometry: dividend magnitudes stay below 2**48, divisors below 2**20.
   localparam int DVD_W     = 48;
   localparam int DSR_W     = 20;
   localparam int DIV_BITS  = 2;
   localparam int DIV_STEPS = DVD_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int MAXLIM_W  = 29;

   // Division by one million: drop six low bits (one million is 64 * 15625), then
   // multiply by the ceiling of 2**56 / 15625 in three 14-bit slices and keep the
   // bits above 2**56. The rounding error stays below one for every 42-bit operand.
   localparam int RCP_PRE   = 6;
   localparam int RCP_Y_W   = DVD_W - RCP_PRE;
   localparam int RCP_CHUNK = 14;
   localparam int RCP_STEPS = RCP_Y_W / RCP_CHUNK;
   localparam int RCP_CNT_W = 2;
   localparam int RCP_M_W   = 43;
   localparam int RCP_SHIFT = 56;
   localparam int RCP_ACC_W = RCP_Y_W + RCP_M_W;
   localparam logic [RCP_M_W-1:0]   RCP_M    = 43'd4611686018428;
   localparam logic [RCP_CNT_W-1:0] RCP_LAST = RCP_CNT_W'(RCP_STEPS);

   localparam logic [DT_W-1:0]  FIRST_DT_US = 17'd8333;
   localparam logic [DT_W-1:0]  DT_MIN_US   = 17'd1000;
   localparam logic [DT_W-1:0]  DT_MAX_US   = 17'd100000;
   localparam logic [DSR_W-1:0] US_PER_S    = 20'd1000000;

   localparam logic signed [ANGLE_W-1:0] AZ_MIN_RST = -26'sd11796480;
   localparam logic signed [ANGLE_W-1:0] AZ_MAX_RST = 26'sd11796480;
   localparam logic signed [ANGLE_W-1:0] EL_MIN_RST = -26'sd5898240;
   localparam logic signed [ANGLE_W-1:0] EL_MAX_RST = 26'sd5898240;
   localparam logic [LIMIT_W-1:0] RATE_RST  = 31'd3932160;
   localparam logic [LIMIT_W-1:0] ACCEL_RST = 31'd19660800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AZ_MIN = 3'd0,
      CSR_AZ_MAX = 3'd1,
      CSR_EL_MIN = 3'd2,
      CSR_EL_MAX = 3'd3,
      CSR_RATE   = 3'd4,
      CSR_ACCEL  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic            start;
      logic [DT_W-1:0] dt;
   } lane_ctl_type;

   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [33:0] x);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sh07FFFFFFF;
      lo = -34'sh080000000;
      if (x > hi) begin
         sat32 = hi[STATE_W-1:0];
      end else if (x < lo) begin
         sat32 = lo[STATE_W-1:0];
      end else begin
         sat32 = x[STATE_W-1:0];
      end
   endfunction

endpackage

[rtl/core/tarl_req_if.sv]
`timescale 1ns / 1ps
interface tarl_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [tarl_pkg::ANGLE_W-1:0] azimuth_target;
   logic signed [tarl_pkg::ANGLE_W-1:0] elevation_target;
   logic [tarl_pkg::ELAPSED_W-1:0]      elapsed_us;
   logic [tarl_pkg::TAG_W-1:0]          command_tag;

   modport source (output valid, azimuth_target, elevation_target, elapsed_us,
                   command_tag, input ready);
   modport sink (input valid, azimuth_target, elevation_target, elapsed_us,
                 command_tag, output ready);
endinterface

[rtl/core/tarl_rsp_if.sv]
`timescale 1ns / 1ps
interface tarl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tarl_pkg::ANGLE_W-1:0] azimuth_command;
   logic signed [tarl_pkg::ANGLE_W-1:0] elevation_command;
   logic [tarl_pkg::TAG_W-1:0]          tag_echo;

   modport source (output valid, azimuth_command, elevation_command, tag_echo,
                   input ready);
   modport sink (input valid, azimuth_command, elevation_command, tag_echo,
                 output ready);
endinterface

[rtl/core/tarl_div.sv]
`timescale 1ns / 1ps
module tarl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tarl_pkg::DVD_W-1:0]   dividend,
   input  logic [tarl_pkg::DSR_W-1:0]   divisor,
   output logic                         done,
   output logic [tarl_pkg::DVD_W-1:0]   quotient
);
   import tarl_pkg::*;

   logic [DSR_W:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [DSR_W-1:0]   dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic               run_ff;
   logic               done_ff;

   // Restoring division, DIV_BITS quotient bits per cycle.
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         rem_in = {rem_in[DSR_W-1:0], dvd_in[DVD_W-1]};
         dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dsr_ff}) begin
            rem_in    = rem_in - {1'b0, dsr_ff};
            dvd_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         cnt_ff <= '0;
         run_ff <= 1'b1;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule

[rtl/core/tarl_lane.sv]
`timescale 1ns / 1ps
module tarl_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tarl_pkg::lane_ctl_type               ctl,
   input  logic signed [tarl_pkg::ANGLE_W-1:0]  target,
   input  logic [tarl_pkg::LIMIT_W-1:0]         rate_limit,
   input  logic [tarl_pkg::LIMIT_W-1:0]         accel_limit,
   output logic                                 done,
   output logic signed [tarl_pkg::STATE_W-1:0]  position
);
   import tarl_pkg::*;

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_MUL  = 4'b0010,
      L_RCP  = 4'b0100,
      L_DIV  = 4'b1000
   } lane_state_type;

   typedef enum logic [1:0] {
      PH_MAX_STEP = 2'd0,
      PH_MAX_DV   = 2'd1,
      PH_VEL      = 2'd2,
      PH_POS      = 2'd3
   } phase_type;

   lane_state_type state_ff;
   phase_type      phase_ff;
   logic           sign_ff;
   logic           done_ff;
   logic [MAXLIM_W-1:0] max_step_ff;
   logic [MAXLIM_W-1:0] max_dv_ff;
   logic signed [STATE_W-1:0] speed_ff;
   logic signed [STATE_W-1:0] pos_ff;
   logic [DVD_W-1:0]     prod_ff;
   logic [RCP_ACC_W-1:0] acc_ff;
   logic [RCP_CNT_W-1:0] rcnt_ff;

   logic signed [33:0] diff, step, step_abs, lim_step, lim_dv;
   logic signed [33:0] spd_x, spd_abs, q_mag, q_sgn, vel_err, dv;
   logic [31:0]        mul_a;
   logic [DSR_W-1:0]   mul_b;
   logic [51:0]        product;
   logic [DSR_W-1:0]   divisor;
   logic               div_done;
   logic [DVD_W-1:0]   quot;
   logic               neg_in;
   logic [RCP_Y_W-1:0]             rcp_y;
   logic [RCP_CHUNK-1:0]           rcp_chunk;
   logic [RCP_CHUNK+RCP_M_W-1:0]   rcp_part;
   logic [RCP_ACC_W-1:0]           acc_in;
   logic [31:0]                    q_raw;
   logic                           fin;

   always_comb begin
      lim_step = $signed({5'b0, max_step_ff});
      lim_dv   = $signed({5'b0, max_dv_ff});
      diff = {{8{target[ANGLE_W-1]}}, target} - {{2{pos_ff[STATE_W-1]}}, pos_ff};
      if (diff > lim_step) begin
         step = lim_step;
      end else if (diff < -lim_step) begin
         step = -lim_step;
      end else begin
         step = diff;
      end
      step_abs = step[33] ? -step : step;
      spd_x    = {{2{speed_ff[STATE_W-1]}}, speed_ff};
      spd_abs  = spd_x[33] ? -spd_x : spd_x;

      case (phase_ff)
         PH_MAX_STEP: begin
            mul_a = {1'b0, rate_limit};
            mul_b = {3'b0, ctl.dt};
            neg_in = 1'b0;
         end
         PH_MAX_DV: begin
            mul_a = {1'b0, accel_limit};
            mul_b = {3'b0, ctl.dt};
            neg_in = 1'b0;
         end
         PH_VEL: begin
            mul_a = step_abs[31:0];
            mul_b = US_PER_S;
            neg_in = step[33];
         end
         PH_POS: begin
            mul_a = spd_abs[31:0];
            mul_b = {3'b0, ctl.dt};
            neg_in = speed_ff[STATE_W-1];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            neg_in = 1'b0;
         end
      endcase
      product = mul_a * mul_b;
      divisor = {3'b0, ctl.dt};

      // Reciprocal multiply for the divisions by one million, most significant
      // slice of the shifted product first.
      rcp_y = prod_ff[DVD_W-1:RCP_PRE];
      case (rcnt_ff)
         2'd0:    rcp_chunk = rcp_y[3*RCP_CHUNK-1 -: RCP_CHUNK];
         2'd1:    rcp_chunk = rcp_y[2*RCP_CHUNK-1 -: RCP_CHUNK];
         default: rcp_chunk = rcp_y[RCP_CHUNK-1:0];
      endcase
      rcp_part = rcp_chunk * RCP_M;
      acc_in   = {acc_ff[RCP_ACC_W-RCP_CHUNK-1:0], {RCP_CHUNK{1'b0}}}
                 + {{(RCP_ACC_W-RCP_CHUNK-RCP_M_W){1'b0}}, rcp_part};

      q_raw = (phase_ff == PH_VEL) ? quot[31:0]
                                   : {3'b0, acc_ff[RCP_ACC_W-1:RCP_SHIFT]};
      fin   = ((state_ff == L_DIV) && div_done)
              || ((state_ff == L_RCP) && (rcnt_ff == RCP_LAST));

      // Results of the last two phases stay below 2**31 in magnitude.
      q_mag   = {2'b0, q_raw};
      q_sgn   = sign_ff ? -q_mag : q_mag;
      vel_err = q_sgn - spd_x;
      if (vel_err > lim_dv) begin
         dv = lim_dv;
      end else if (vel_err < -lim_dv) begin
         dv = -lim_dv;
      end else begin
         dv = vel_err;
      end
   end

   tarl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == L_MUL) && (phase_ff == PH_VEL)),
      .dividend (product[DVD_W-1:0]),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (ctl.start) begin
               phase_ff <= PH_MAX_STEP;
               state_ff <= L_MUL;
            end
         end
         L_MUL: begin
            sign_ff  <= neg_in;
            prod_ff  <= product[DVD_W-1:0];
            acc_ff   <= '0;
            rcnt_ff  <= '0;
            state_ff <= (phase_ff == PH_VEL) ? L_DIV : L_RCP;
         end
         L_RCP: begin
            if (!fin) begin
               acc_ff  <= acc_in;
               rcnt_ff <= rcnt_ff + 1'b1;
            end
         end
         L_DIV: ;
         default: state_ff <= L_IDLE;
      endcase
      if (fin) begin
         case (phase_ff)
            PH_MAX_STEP: max_step_ff <= q_raw[MAXLIM_W-1:0];
            PH_MAX_DV:   max_dv_ff   <= q_raw[MAXLIM_W-1:0];
            PH_VEL:      speed_ff    <= sat32(spd_x + dv);
            PH_POS: pos_ff <= sat32({{2{pos_ff[STATE_W-1]}}, pos_ff} + q_sgn);
            default: ;
         endcase
         if (phase_ff == PH_POS) begin
            done_ff  <= 1'b1;
            state_ff <= L_IDLE;
         end else begin
            phase_ff <= phase_type'(phase_ff + 2'd1);
            state_ff <= L_MUL;
         end
      end
      if (reset) begin
         state_ff <= L_IDLE;
         phase_ff <= PH_MAX_STEP;
         done_ff  <= 1'b0;
         speed_ff <= '0;
         pos_ff   <= '0;
      end
   end

   assign done     = done_ff;
   assign position = pos_ff;
endmodule

[rtl/core/two_axis_rate_accel_limiter.sv]
`timescale 1ns / 1ps
// Channel   Direction  Carries
// req_bus   in         azimuth_target, elevation_target, elapsed_us, command_tag
// rsp_bus   out        azimuth_command, elevation_command, tag_echo
// csr_*     in         write-only limits and window bounds, one register per beat
//
// Every axis lane runs four multiply phases: the three that divide by one million use a
// reciprocal multiply over three 14-bit slices, and the velocity phase divides by the
// time step in a divider that retires two quotient bits per cycle over a 48-bit
// dividend. One item is in flight at a time, so a beat is accepted only after the
// result of the previous one is loaded. A finished result waits in the output register,
// and the next beat is accepted while it waits. Reset is synchronous and clears the kept
// positions and speeds, the first-item flag and the limits to their defaults. A stalled
// result holds back the loading of the next one and so the acceptance of later beats.
module two_axis_rate_accel_limiter (
   input  logic                              clock,
   input  logic                              reset,
   tarl_req_if.sink                          req_bus,
   tarl_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [tarl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tarl_pkg::CSR_DAT_W-1:0]    csr_data
);
   import tarl_pkg::*;
`include "two_axis_rate_accel_limiter_defines.svh"

   // Configuration registers.
   logic signed [ANGLE_W-1:0] az_min_ff, az_max_ff, el_min_ff, el_max_ff;
   logic [LIMIT_W-1:0]        rate_ff, accel_ff;

   // The item in flight: targets, time step and tag are held for the whole run.
   logic signed [ANGLE_W-1:0] az_tgt_ff, el_tgt_ff;
   logic [TAG_W-1:0]          tag_ff;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic                      seen_ff;
   logic                      busy_ff;
   logic                      start_ff;
   logic                      az_done_ff, el_done_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] az_cmd_ff, el_cmd_ff, az_cmd_in, el_cmd_in;
   logic [TAG_W-1:0]          tag_out_ff;

   lane_ctl_type              lane_ctl;
   logic                      az_done, el_done;
   logic signed [STATE_W-1:0] az_pos, el_pos;
   logic                      accept, load;

   assign req_bus.ready = !busy_ff;
   assign accept        = req_bus.valid && !busy_ff;
   // The merged result moves out once both lanes are finished and the slot is free.
   assign load          = busy_ff && az_done_ff && el_done_ff
                          && (!rsp_valid_ff || rsp_bus.ready);

   // The first item after reset uses 1/120 s; later ones saturate the elapsed time.
   always_comb begin
      if (!seen_ff) begin
         dt_in = FIRST_DT_US;
      end else if (req_bus.elapsed_us < {3'b0, DT_MIN_US}) begin
         dt_in = DT_MIN_US;
      end else if (req_bus.elapsed_us > {3'b0, DT_MAX_US}) begin
         dt_in = DT_MAX_US;
      end else begin
         dt_in = req_bus.elapsed_us[DT_W-1:0];
      end
   end

   assign lane_ctl.start = start_ff;
   assign lane_ctl.dt    = dt_ff;

   tarl_lane u_az (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lane_ctl),
      .target      (az_tgt_ff),
      .rate_limit  (rate_ff),
      .accel_limit (accel_ff),
      .done        (az_done),
      .position    (az_pos)
   );

   tarl_lane u_el (
      .clock       (clock),
      .reset       (reset),
      .ctl         (lane_ctl),
      .target      (el_tgt_ff),
      .rate_limit  (rate_ff),
      .accel_limit (accel_ff),
      .done        (el_done),
      .position    (el_pos)
   );

   // Window clamp. With an inverted window the lower bound wins.
   always_comb begin
      if (az_pos < STATE_W'(az_min_ff)) begin
         az_cmd_in = az_min_ff;
      end else if (az_pos > STATE_W'(az_max_ff)) begin
         az_cmd_in = az_max_ff;
      end else begin
         az_cmd_in = az_pos[ANGLE_W-1:0];
      end
      if (el_pos < STATE_W'(el_min_ff)) begin
         el_cmd_in = el_min_ff;
      end else if (el_pos > STATE_W'(el_max_ff)) begin
         el_cmd_in = el_max_ff;
      end else begin
         el_cmd_in = el_pos[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (csr_we) begin
         case (csr_index)
            CSR_AZ_MIN: az_min_ff <= csr_data[ANGLE_W-1:0];
            CSR_AZ_MAX: az_max_ff <= csr_data[ANGLE_W-1:0];
            CSR_EL_MIN: el_min_ff <= csr_data[ANGLE_W-1:0];
            CSR_EL_MAX: el_max_ff <= csr_data[ANGLE_W-1:0];
            CSR_RATE:   rate_ff   <= csr_data[LIMIT_W-1:0];
            CSR_ACCEL:  accel_ff  <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end

      start_ff <= accept;
      if (accept) begin
         az_tgt_ff <= req_bus.azimuth_target;
         el_tgt_ff <= req_bus.elevation_target;
         tag_ff    <= req_bus.command_tag;
         dt_ff     <= dt_in;
         seen_ff   <= 1'b1;
         busy_ff   <= 1'b1;
      end

      if (az_done) begin
         az_done_ff <= 1'b1;
      end
      if (el_done) begin
         el_done_ff <= 1'b1;
      end

      if (load) begin
         az_cmd_ff    <= az_cmd_in;
         el_cmd_ff    <= el_cmd_in;
         tag_out_ff   <= tag_ff;
         rsp_valid_ff <= 1'b1;
         busy_ff      <= 1'b0;
         az_done_ff   <= 1'b0;
         el_done_ff   <= 1'b0;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end

      if (reset) begin
         az_min_ff    <= AZ_MIN_RST;
         az_max_ff    <= AZ_MAX_RST;
         el_min_ff    <= EL_MIN_RST;
         el_max_ff    <= EL_MAX_RST;
         rate_ff      <= RATE_RST;
         accel_ff     <= ACCEL_RST;
         seen_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         az_done_ff   <= 1'b0;
         el_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.azimuth_command   = az_cmd_ff;
   assign rsp_bus.elevation_command = el_cmd_ff;
   assign rsp_bus.tag_echo          = tag_out_ff;

   // An accepted beat keeps the block busy until its result is loaded.
   `TARL_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)
   // Lanes only finish while an item is in flight.
   `TARL_ASSERT_SAME(a_az_done_busy, clock, reset, az_done || el_done, busy_ff)
   // A lane start is a single-cycle pulse, never repeated for one item.
   `TARL_ASSERT_NEXT(a_start_pulse, clock, reset, start_ff, !start_ff && busy_ff)
   // Finished flags never stand without an item in flight.
   `TARL_ASSERT_SAME(a_done_flags, clock, reset, az_done_ff || el_done_ff, busy_ff)
endmodule
